// ===== src/hac_pkg.sv =====
// Shared types, codes and defaults for the handle allocator with compaction.
package hac_pkg;

    localparam int unsigned POOL_BYTES_DEF  = 65536;
    localparam int unsigned MAX_OBJECTS_DEF = 32;

    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned ADDR_W   = 17;
    localparam int unsigned REFS_W   = 8;

    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_RETRIEVE = 2'd1,
        ACT_ADD_REF  = 2'd2,
        ACT_DROP_REF = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_OOM      = 3'd2,
        ST_FULL     = 3'd3,
        ST_MOVE     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_COMPACT,
        S_FINAL
    } t_state;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_MOVE,
        EM_INSERT,
        EM_MISS,
        EM_HIT
    } t_emit;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ADDR_W-1:0]   start;
        logic [ADDR_W-1:0]   length;
        logic [REFS_W-1:0]   refs;
    } t_entry;

    typedef struct packed {
        logic  load;
        logic  step;
        logic  keep;
        logic  drop;
        logic  swap;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic at_end;
        logic hit;
        logic refs_nz;
        logic need_compact;
        logic out_free;
    } t_sts;

endpackage

// ===== src/hac_ctrl.sv =====
// Sequencer for insert, lookup and compaction walks.
module hac_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_action,
    input  hac_pkg::t_sts     i_sts,
    output hac_pkg::t_cmd     o_cmd,
    output logic              o_busy
);

    hac_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hac_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '{load: 1'b0, step: 1'b0, keep: 1'b0, drop: 1'b0, swap: 1'b0,
                    emit: hac_pkg::EM_NONE};
        o_busy  = (r_state != hac_pkg::S_IDLE);
        unique case (r_state)
            hac_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (hac_pkg::t_action'(i_action) == hac_pkg::ACT_INSERT) begin
                        n_state = i_sts.need_compact ? hac_pkg::S_COMPACT
                                                     : hac_pkg::S_FINAL;
                    end else begin
                        n_state = hac_pkg::S_LOOKUP;
                    end
                end
            end
            hac_pkg::S_LOOKUP: begin
                if (i_sts.at_end) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = hac_pkg::EM_MISS;
                        n_state    = hac_pkg::S_IDLE;
                    end
                end else if (i_sts.hit) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = hac_pkg::EM_HIT;
                        n_state    = hac_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            hac_pkg::S_COMPACT: begin
                if (i_sts.at_end) begin
                    o_cmd.swap = 1'b1;
                    n_state    = hac_pkg::S_FINAL;
                end else if (i_sts.refs_nz) begin
                    if (i_sts.out_free) begin
                        o_cmd.keep = 1'b1;
                        o_cmd.emit = hac_pkg::EM_MOVE;
                    end
                end else begin
                    o_cmd.drop = 1'b1;
                end
            end
            hac_pkg::S_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = hac_pkg::EM_INSERT;
                    n_state    = hac_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hac_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/hac_datapath.sv =====
// Slot table memory, pool counters, walk index and output register.
module hac_datapath #(
    parameter int unsigned POOL_BYTES  = hac_pkg::POOL_BYTES_DEF,
    parameter int unsigned MAX_OBJECTS = hac_pkg::MAX_OBJECTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hac_pkg::t_cmd                i_cmd,
    output hac_pkg::t_sts                o_sts,
    input  logic [1:0]                   i_action,
    input  logic [hac_pkg::ADDR_W-1:0]   i_object_size,
    input  logic [hac_pkg::HANDLE_W-1:0] i_handle,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic [hac_pkg::HANDLE_W-1:0] o_handle_out,
    output logic [hac_pkg::ADDR_W-1:0]   o_start_address,
    output logic [hac_pkg::ADDR_W-1:0]   o_move_source,
    output logic [hac_pkg::ADDR_W-1:0]   o_move_destination,
    output logic [hac_pkg::ADDR_W-1:0]   o_move_length,
    output logic [hac_pkg::ADDR_W-1:0]   o_bytes_freed,
    output logic                         o_last
);

    localparam int unsigned IW = $clog2(MAX_OBJECTS + 1);
    localparam int unsigned AW = $clog2(MAX_OBJECTS);
    localparam int unsigned FW = $clog2(POOL_BYTES + 1);
    localparam int unsigned SW = ((FW > hac_pkg::ADDR_W) ? FW : hac_pkg::ADDR_W) + 1;
    localparam logic [SW-1:0] POOL = SW'(POOL_BYTES);
    localparam logic [IW-1:0] MAXN = IW'(MAX_OBJECTS);
    localparam logic [hac_pkg::REFS_W-1:0] REFS_MAX = '1;

    hac_pkg::t_entry mem [0:(1 << AW)-1];
    hac_pkg::t_entry r_rd;

    logic [IW-1:0]               r_count, r_idx, r_wr, n_idx;
    logic [FW-1:0]               r_fill, r_acc, r_freed;
    logic                        r_half;
    logic [hac_pkg::HANDLE_W-1:0] r_next_h;
    logic [1:0]                  r_action;
    logic [hac_pkg::ADDR_W-1:0]  r_size;
    logic [hac_pkg::HANDLE_W-1:0] r_handle;
    logic                        r_out_valid;

    logic                        fits_in, fits_q, full_q, ins_ok, ref_wr, we;
    logic [SW-1:0]               dst_w, ins_w;
    logic [AW-1:0]               wa;
    hac_pkg::t_entry             wd;
    logic [hac_pkg::REFS_W-1:0]  refs_new;
    logic [hac_pkg::HANDLE_W-1:0] h_inc;

    logic [2:0]                   n_status;
    logic [hac_pkg::HANDLE_W-1:0] n_handle_out;
    logic [hac_pkg::ADDR_W-1:0]   n_start_address;
    logic [hac_pkg::ADDR_W-1:0]   n_move_source;
    logic [hac_pkg::ADDR_W-1:0]   n_move_destination;
    logic [hac_pkg::ADDR_W-1:0]   n_move_length;
    logic [hac_pkg::ADDR_W-1:0]   n_bytes_freed;
    logic                         n_last;

    assign fits_in = (SW'(i_object_size) + SW'(r_fill)) <= POOL;
    assign fits_q  = (SW'(r_size) + SW'(r_fill)) <= POOL;
    assign full_q  = (r_count >= MAXN);
    assign ins_ok  = (i_cmd.emit == hac_pkg::EM_INSERT) && fits_q && !full_q;
    assign ref_wr  = (i_cmd.emit == hac_pkg::EM_HIT) &&
                     (hac_pkg::t_action'(r_action) != hac_pkg::ACT_RETRIEVE);
    assign dst_w   = (r_half ? SW'(0) : POOL) + SW'(r_acc);
    assign ins_w   = (r_half ? POOL : SW'(0)) + SW'(r_fill);
    assign h_inc   = r_next_h + 1'b1;

    assign o_sts.at_end       = (r_idx == r_count);
    assign o_sts.hit          = (r_rd.handle == r_handle);
    assign o_sts.refs_nz      = (r_rd.refs != '0);
    assign o_sts.need_compact = (!fits_in || (r_count >= MAXN)) && (r_count != '0);
    assign o_sts.out_free     = !r_out_valid || !i_stall;

    always_comb begin
        if (i_cmd.load) begin
            n_idx = '0;
        end else if (i_cmd.step || i_cmd.keep || i_cmd.drop) begin
            n_idx = r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_comb begin
        if (hac_pkg::t_action'(r_action) == hac_pkg::ACT_ADD_REF) begin
            refs_new = (r_rd.refs == REFS_MAX) ? r_rd.refs : r_rd.refs + 1'b1;
        end else begin
            refs_new = '0;
        end
        we = i_cmd.keep || ins_ok || ref_wr;
        wa = r_idx[AW-1:0];
        wd = r_rd;
        priority if (i_cmd.keep) begin
            wa       = r_wr[AW-1:0];
            wd.start = dst_w[hac_pkg::ADDR_W-1:0];
        end else if (ins_ok) begin
            wa = r_count[AW-1:0];
            wd = '{handle: r_next_h, start: ins_w[hac_pkg::ADDR_W-1:0],
                   length: r_size, refs: hac_pkg::REFS_W'(1)};
        end else begin
            wd.refs = refs_new;
        end
    end

    // Table memory: one write port, registered read at the next walk index.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[n_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_wr        <= '0;
            r_fill      <= '0;
            r_acc       <= '0;
            r_freed     <= '0;
            r_half      <= 1'b0;
            r_next_h    <= hac_pkg::HANDLE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.load) begin
                r_wr    <= '0;
                r_acc   <= '0;
                r_freed <= '0;
            end
            if (i_cmd.keep) begin
                r_wr  <= r_wr + 1'b1;
                r_acc <= r_acc + FW'(r_rd.length);
            end
            if (i_cmd.drop) begin
                r_freed <= r_freed + FW'(r_rd.length);
            end
            if (i_cmd.swap) begin
                r_count <= r_wr;
                r_fill  <= r_acc;
                r_half  <= ~r_half;
            end
            if (ins_ok) begin
                r_count  <= r_count + 1'b1;
                r_fill   <= r_fill + FW'(r_size);
                r_next_h <= (h_inc == '0) ? hac_pkg::HANDLE_W'(1) : h_inc;
            end
            if (i_cmd.emit != hac_pkg::EM_NONE) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Next result transaction for the output register
    always_comb begin
        n_status           = hac_pkg::ST_OK;
        n_handle_out       = '0;
        n_start_address    = '0;
        n_move_source      = '0;
        n_move_destination = '0;
        n_move_length      = '0;
        n_bytes_freed      = '0;
        n_last             = 1'b1;
        unique case (i_cmd.emit)
            hac_pkg::EM_MOVE: begin
                n_status           = hac_pkg::ST_MOVE;
                n_move_source      = r_rd.start;
                n_move_destination = dst_w[hac_pkg::ADDR_W-1:0];
                n_move_length      = r_rd.length;
                n_last             = 1'b0;
            end
            hac_pkg::EM_INSERT: begin
                n_bytes_freed = hac_pkg::ADDR_W'(r_freed);
                if (!fits_q) begin
                    n_status = hac_pkg::ST_OOM;
                end else if (full_q) begin
                    n_status = hac_pkg::ST_FULL;
                end else begin
                    n_handle_out    = r_next_h;
                    n_start_address = ins_w[hac_pkg::ADDR_W-1:0];
                end
            end
            hac_pkg::EM_MISS: begin
                n_status = hac_pkg::ST_NOTFOUND;
            end
            hac_pkg::EM_HIT: begin
                if (hac_pkg::t_action'(r_action) == hac_pkg::ACT_RETRIEVE) begin
                    n_start_address = r_rd.start;
                end
            end
            default: begin
                n_status = hac_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_size   <= i_object_size;
            r_handle <= i_handle;
        end
        if (i_cmd.emit != hac_pkg::EM_NONE) begin
            o_status           <= n_status;
            o_handle_out       <= n_handle_out;
            o_start_address    <= n_start_address;
            o_move_source      <= n_move_source;
            o_move_destination <= n_move_destination;
            o_move_length      <= n_move_length;
            o_bytes_freed      <= n_bytes_freed;
            o_last             <= n_last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== src/handle_allocator_with_compaction.sv =====
// Top level of the handle allocator with copying compaction.
// The block keeps a packed table of up to MAX_OBJECTS slots over a pool split
// into two halves of POOL_BYTES each, and takes one transaction at a time:
// o_stall stays high from acceptance until the final result is
// loaded into the output register. An insert that fits, or meets an empty
// table, goes straight to its final result; retrieve, add reference and drop
// reference walk the slots in insertion order, one slot a cycle through the
// table memory's single read port, until a hit or the end of the table. Any
// other insert that does not fit, or meets a full table, first compacts: one
// occupied slot a cycle, while a live slot waits as long as the output side
// holds i_stall, each live slot producing a move transaction (status 4,
// last 0) for an outside mover, then the half toggles and the final result
// follows. bytes_freed on the final insert result sums the lengths of the
// dropped zero-reference slots.
// Handles count up from 1 and skip 0 on wrap.
module handle_allocator_with_compaction #(
    parameter int unsigned POOL_BYTES  = hac_pkg::POOL_BYTES_DEF,
    parameter int unsigned MAX_OBJECTS = hac_pkg::MAX_OBJECTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_action,
    input  logic [hac_pkg::ADDR_W-1:0]   i_object_size,
    input  logic [hac_pkg::HANDLE_W-1:0] i_handle,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic [hac_pkg::HANDLE_W-1:0] o_handle_out,
    output logic [hac_pkg::ADDR_W-1:0]   o_start_address,
    output logic [hac_pkg::ADDR_W-1:0]   o_move_source,
    output logic [hac_pkg::ADDR_W-1:0]   o_move_destination,
    output logic [hac_pkg::ADDR_W-1:0]   o_move_length,
    output logic [hac_pkg::ADDR_W-1:0]   o_bytes_freed,
    output logic                         o_last
);

    hac_pkg::t_cmd cmd;
    hac_pkg::t_sts sts;

    // Sequencer: decides walk steps, moves and the final result.
    hac_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (o_stall)
    );

    // Table, pool counters and the output register.
    hac_datapath #(
        .POOL_BYTES  (POOL_BYTES),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_action           (i_action),
        .i_object_size      (i_object_size),
        .i_handle           (i_handle),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_handle_out       (o_handle_out),
        .o_start_address    (o_start_address),
        .o_move_source      (o_move_source),
        .o_move_destination (o_move_destination),
        .o_move_length      (o_move_length),
        .o_bytes_freed      (o_bytes_freed),
        .o_last             (o_last)
    );

endmodule
